// ===== sv/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/lco_pkg.sv =====
// types, constants and color functions for the label color overlay
package lco_pkg;

    localparam int LABEL_BITS_DEF = 16;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_COMPONENT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_MODE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_WEIGHT    = 2'd2;

    localparam int COUNT_W  = 16;
    localparam int WEIGHT_W = 9;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 9'd128;

    localparam int HUE_W      = 8;
    localparam int HUE_RANGE  = 180;
    localparam int HUE_STEP0  = 45;
    localparam int HUE_OFFSET = 90;

    // (37 * 256^i) mod 180 for byte i of the label
    localparam int MAX_BYTES = 4;
    localparam int FOLD_WEIGHT [MAX_BYTES] = '{37, 112, 52, 172};

    // folded sum: 255 * (37 + 112 + 52 + 172) + 90 fits in 17 bits
    localparam int FOLD_W  = 17;
    localparam int RECIP_SHIFT = 25;
    localparam int RECIP   = ((1 << RECIP_SHIFT) + HUE_RANGE - 1) / HUE_RANGE;
    localparam int RECIP_W = 18;
    localparam int QUOT_W  = 10;

    localparam int SECTOR_LEN = 30;

    localparam int BLEND_W = 20;

    typedef struct packed {
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
    } bgr_t;

    typedef enum logic [2:0] {
        SEC_R2Y = 3'd0,
        SEC_Y2G = 3'd1,
        SEC_G2C = 3'd2,
        SEC_C2B = 3'd3,
        SEC_B2M = 3'd4,
        SEC_M2R = 3'd5
    } sector_t;

    // n/2 rounded half to even
    function automatic logic [7:0] half_even(input logic [8:0] n);
        return n[8:1] + {7'd0, n[0] & n[1]};
    endfunction

    // hsv to bgr at full saturation and value
    function automatic bgr_t hue_color(input logic [HUE_W-1:0] hue);
        sector_t           sec;
        logic [HUE_W-1:0]  base;
        logic [4:0]        k;
        logic [8:0]        ramp;
        logic [7:0]        up;
        logic [7:0]        dn;
        bgr_t              c;
        if (hue < 8'd30) begin
            sec = SEC_R2Y; base = 8'd0;
        end else if (hue < 8'd60) begin
            sec = SEC_Y2G; base = 8'd30;
        end else if (hue < 8'd90) begin
            sec = SEC_G2C; base = 8'd60;
        end else if (hue < 8'd120) begin
            sec = SEC_C2B; base = 8'd90;
        end else if (hue < 8'd150) begin
            sec = SEC_B2M; base = 8'd120;
        end else begin
            sec = SEC_M2R; base = 8'd150;
        end
        k    = 5'(hue - base);
        ramp = 9'(k) * 9'd17;
        up   = half_even(ramp);
        dn   = half_even(9'd510 - ramp);
        case (sec)
            SEC_R2Y: c = '{b: 8'd0,   g: up,    r: 8'd255};
            SEC_Y2G: c = '{b: 8'd0,   g: 8'd255, r: dn};
            SEC_G2C: c = '{b: up,     g: 8'd255, r: 8'd0};
            SEC_C2B: c = '{b: 8'd255, g: dn,    r: 8'd0};
            SEC_B2M: c = '{b: 8'd255, g: 8'd0,  r: up};
            SEC_M2R: c = '{b: dn,     g: 8'd0,  r: 8'd255};
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// ===== sv/label_color_overlay.sv =====
// label color overlay: six-stage pixel pipeline from gray and label to blended bgr
// throughput: one word per cycle while out_ready is high; each stage holds one word and fills bubbles on stall
// the hue remainder mod 180 takes a fold, a reciprocal multiply and a correction stage
// reset clears all stage valid bits and sets the registers to count 0, mode 0, weight 128
`include "assert_macros.svh"

module label_color_overlay
    import lco_pkg::*;
#(
    parameter int LABEL_BITS = LABEL_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            gray_level,
    input  logic [LABEL_BITS-1:0] label_id,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            blue_out,
    output logic [7:0]            green_out,
    output logic [7:0]            red_out
);

    localparam int NSTAGE = 6;
    localparam int NBYTES = (LABEL_BITS + 7) / 8;
    localparam int PAD_W  = NBYTES * 8;
    localparam int CMP_W  = (LABEL_BITS > COUNT_W) ? LABEL_BITS : COUNT_W;
    localparam int PROD_W = FOLD_W + RECIP_W;

    // configuration registers
    logic [COUNT_W-1:0]  count_reg;
    logic                mode_reg;
    logic [WEIGHT_W-1:0] weight_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            mode_reg   <= 1'b0;
            weight_reg <= WEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_COMPONENT_COUNT: count_reg  <= cfg_data;
                CFG_PALETTE_MODE:    mode_reg   <= cfg_data[0];
                CFG_BLEND_WEIGHT:    weight_reg <= cfg_data[WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // stage handshake
    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE-1:0] vld_next;
    logic [NSTAGE-1:0] adv;

    always_comb
    begin
        adv[NSTAGE-1] = !vld_reg[NSTAGE-1] || out_ready;
        for (int i = NSTAGE - 2; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
        vld_next[0] = adv[0] ? in_valid : vld_reg[0];
        for (int i = 1; i < NSTAGE; i++)
        begin
            vld_next[i] = adv[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[NSTAGE-1];

    // stage 1: byte fold of the label, class of the label
    logic [PAD_W-1:0]  lbl_pad;
    logic [FOLD_W-1:0] fold_next;
    logic              bg_next;
    logic              col_next;

    always_comb
    begin
        lbl_pad   = PAD_W'(label_id);
        fold_next = FOLD_W'(HUE_OFFSET);
        for (int i = 0; i < NBYTES; i++)
        begin
            fold_next = fold_next + FOLD_W'(lbl_pad[i*8 +: 8]) * FOLD_W'(FOLD_WEIGHT[i]);
        end
        bg_next  = (label_id == '0);
        col_next = (CMP_W'(label_id) <= CMP_W'(count_reg));
    end

    logic [7:0]        gray1_reg, gray2_reg, gray3_reg, gray4_reg, gray5_reg;
    logic              bg1_reg, bg2_reg, bg3_reg;
    logic              col1_reg, col2_reg, col3_reg;
    logic [1:0]        lsb1_reg, lsb2_reg;
    logic [FOLD_W-1:0] fold1_reg, fold2_reg;
    logic [QUOT_W-1:0] quot2_reg;
    logic [HUE_W-1:0]  hue3_reg;
    bgr_t              col4_reg;
    logic signed [BLEND_W-1:0] sum5_b_reg, sum5_g_reg, sum5_r_reg;
    logic [7:0]        b6_reg, g6_reg, r6_reg;

    // stage 2: reciprocal multiply for the quotient by 180
    logic [PROD_W-1:0] prod2;
    assign prod2 = PROD_W'(fold1_reg) * PROD_W'(RECIP);

    // stage 3: remainder with correction, hue select
    logic [FOLD_W-1:0] rem3_raw;
    logic [FOLD_W-1:0] rem3;
    logic [HUE_W-1:0]  hue0_3;
    logic [HUE_W-1:0]  hue3_next;

    always_comb
    begin
        rem3_raw = fold2_reg - FOLD_W'(quot2_reg) * FOLD_W'(HUE_RANGE);
        rem3     = (rem3_raw >= FOLD_W'(HUE_RANGE)) ? rem3_raw - FOLD_W'(HUE_RANGE) : rem3_raw;
        hue0_3   = HUE_W'(lsb2_reg) * HUE_W'(HUE_STEP0);
        hue3_next = mode_reg ? rem3[HUE_W-1:0] : hue0_3;
    end

    // stage 4: hue to color, background passes gray, labels above the count give black
    bgr_t col4_next;

    always_comb
    begin
        if (bg3_reg)
            col4_next = '{b: gray3_reg, g: gray3_reg, r: gray3_reg};
        else if (col3_reg)
            col4_next = hue_color(hue3_reg);
        else
            col4_next = '0;
    end

    // stage 5: 256*g + a*(c-g)
    function automatic logic signed [BLEND_W-1:0] blend_sum(
        input logic [7:0]          c,
        input logic [7:0]          g,
        input logic [WEIGHT_W-1:0] a
    );
        logic signed [8:0]        diff;
        logic signed [WEIGHT_W:0] a_s;
        diff = $signed({1'b0, c}) - $signed({1'b0, g});
        a_s  = $signed({1'b0, a});
        return BLEND_W'(a_s) * BLEND_W'(diff) + $signed(BLEND_W'({g, 8'd0}));
    endfunction

    // stage 6: round half to even and clamp
    function automatic logic [7:0] round_clamp(input logic signed [BLEND_W-1:0] s);
        logic signed [BLEND_W-9:0] q;
        logic                      inc;
        logic signed [BLEND_W-8:0] v;
        q   = $signed(s[BLEND_W-1:8]);
        inc = (s[7:0] > 8'd128) || ((s[7:0] == 8'd128) && q[0]);
        v   = $signed({q[BLEND_W-9], q}) + $signed({{(BLEND_W-8){1'b0}}, inc});
        if (v < 0)
            return 8'd0;
        else if (v > $signed((BLEND_W-7)'(255)))
            return 8'd255;
        else
            return v[7:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            gray1_reg <= gray_level;
            bg1_reg   <= bg_next;
            col1_reg  <= col_next;
            lsb1_reg  <= label_id[1:0];
            fold1_reg <= fold_next;
        end
        if (adv[1])
        begin
            gray2_reg <= gray1_reg;
            bg2_reg   <= bg1_reg;
            col2_reg  <= col1_reg;
            lsb2_reg  <= lsb1_reg;
            fold2_reg <= fold1_reg;
            quot2_reg <= prod2[RECIP_SHIFT +: QUOT_W];
        end
        if (adv[2])
        begin
            gray3_reg <= gray2_reg;
            bg3_reg   <= bg2_reg;
            col3_reg  <= col2_reg;
            hue3_reg  <= hue3_next;
        end
        if (adv[3])
        begin
            gray4_reg <= gray3_reg;
            col4_reg  <= col4_next;
        end
        if (adv[4])
        begin
            gray5_reg  <= gray4_reg;
            sum5_b_reg <= blend_sum(col4_reg.b, gray4_reg, weight_reg);
            sum5_g_reg <= blend_sum(col4_reg.g, gray4_reg, weight_reg);
            sum5_r_reg <= blend_sum(col4_reg.r, gray4_reg, weight_reg);
        end
        if (adv[5])
        begin
            b6_reg <= round_clamp(sum5_b_reg);
            g6_reg <= round_clamp(sum5_g_reg);
            r6_reg <= round_clamp(sum5_r_reg);
        end
    end

    assign blue_out  = b6_reg;
    assign green_out = g6_reg;
    assign red_out   = r6_reg;

    // gray5 follows gray4 for the background check below
    `ASSERT_IMPLIES(a_rem_range, clk, rst_n, vld_reg[1], rem3 < FOLD_W'(HUE_RANGE))
    `ASSERT_IMPLIES(a_hue_range, clk, rst_n, vld_reg[2], hue3_reg < HUE_W'(HUE_RANGE))
    `ASSERT_NEXT(a_bg_gray, clk, rst_n, vld_reg[2] && adv[3] && bg3_reg,
        col4_reg.b == gray4_reg && col4_reg.r == gray4_reg)
    `ASSERT_NEXT(a_bg_sum, clk, rst_n, vld_reg[3] && adv[4] && col4_reg.g == gray4_reg,
        sum5_g_reg == $signed(BLEND_W'({gray5_reg, 8'd0})))

endmodule
